// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the line field tagger checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// Next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: hdl/lftag_pkg.sv
// ---------------------------------------------------------------------------
// lftag_pkg
// Widths, character codes, tag codes and inter-module types of the line
// field tagger.
// ---------------------------------------------------------------------------
`default_nettype none

package lftag_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PARAM_W = 4;
   localparam int unsigned TAG_W   = 3;

   // Characters of interest
   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

   // Reset value of the parameter limit register
   localparam logic [PARAM_W-1:0] PARAM_LIMIT = 4'd15;

   // Result tags
   localparam logic [TAG_W-1:0] TAG_IGNORED = 3'd0;
   localparam logic [TAG_W-1:0] TAG_PREFIX  = 3'd1;
   localparam logic [TAG_W-1:0] TAG_ORIGIN  = 3'd2;
   localparam logic [TAG_W-1:0] TAG_CMD     = 3'd3;
   localparam logic [TAG_W-1:0] TAG_PARAM   = 3'd4;
   localparam logic [TAG_W-1:0] TAG_BCOLON  = 3'd5;
   localparam logic [TAG_W-1:0] TAG_BODY    = 3'd6;
   localparam logic [TAG_W-1:0] TAG_END     = 3'd7;

   // Class of one request as seen by the back end
   typedef enum logic [1:0] {
      CLS_OTHER,
      CLS_COLON,
      CLS_SPACE,
      CLS_END
   } char_class_type;

   // Front end to queue
   typedef struct packed {
      logic           push;
      char_class_type cls;
   } q_push_type;

   // Queue to front and back end
   typedef struct packed {
      logic           full;
      logic           empty;
      char_class_type head;
   } q_status_type;

endpackage

`default_nettype wire

// File: hdl/lftag_ifs.sv
// ---------------------------------------------------------------------------
// lftag_ifs
// Valid/ready channel interfaces for the request and result streams.
// ---------------------------------------------------------------------------
`default_nettype none

interface lftag_req_if;
   import lftag_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              flush;

   modport source (output valid, output data_byte, output flush, input ready);
   modport sink   (input valid, input data_byte, input flush, output ready);
endinterface

interface lftag_rsp_if;
   import lftag_pkg::*;

   logic               valid;
   logic               ready;
   logic [TAG_W-1:0]   tag;
   logic [PARAM_W-1:0] param_index;
   logic               token_start;
   logic               line_valid;
   logic [PARAM_W-1:0] param_count;
   logic               has_origin;
   logic               has_body;

   modport source (output valid, output tag, output param_index, output token_start,
                   output line_valid, output param_count, output has_origin,
                   output has_body, input ready);
   modport sink   (input valid, input tag, input param_index, input token_start,
                   input line_valid, input param_count, input has_origin,
                   input has_body, output ready);
endinterface

`default_nettype wire

// File: hdl/lftag_front.sv
// ---------------------------------------------------------------------------
// lftag_front
// Accepts requests and reduces each one to its character class before it
// enters the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module lftag_front (
   lftag_req_if.sink          req_if,
   input  lftag_pkg::q_status_type q_status,
   output lftag_pkg::q_push_type   q_push
);
   import lftag_pkg::*;

   char_class_type cls;

   // Classify: flush and CR/LF close a line
   always_comb begin
      if (req_if.flush || req_if.data_byte == CHAR_CR || req_if.data_byte == CHAR_LF) begin
         cls = CLS_END;
      end else if (req_if.data_byte == CHAR_COLON) begin
         cls = CLS_COLON;
      end else if (req_if.data_byte == CHAR_SPACE) begin
         cls = CLS_SPACE;
      end else begin
         cls = CLS_OTHER;
      end
   end

   // Take a request whenever the queue has room
   assign req_if.ready = !q_status.full;
   assign q_push.push  = req_if.valid && !q_status.full;
   assign q_push.cls   = cls;

endmodule

`default_nettype wire

// File: hdl/lftag_queue.sv
// ---------------------------------------------------------------------------
// lftag_queue
// Small circular queue of classified requests between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module lftag_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  lftag_pkg::q_push_type    q_push,
   input  wire                      pop,
   output lftag_pkg::q_status_type  q_status
);
   import lftag_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   char_class_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_status.head  = entry_ff[rd_ptr_ff];

   assign do_push = q_push.push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.cls;
      end
   end

endmodule

`default_nettype wire

// File: hdl/lftag_back.sv
// ---------------------------------------------------------------------------
// lftag_back
// Line state machine: tags each queued request and keeps the per-line
// summary, with a registered result stage towards the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module lftag_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wr_en,
   input  wire [lftag_pkg::PARAM_W-1:0]        csr_wr_data,
   input  lftag_pkg::q_status_type             q_status,
   output logic                                pop,
   lftag_rsp_if.source                         rsp_if
);
   import lftag_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ORIGIN,
      PH_GAP,
      PH_CMD,
      PH_PARAM,
      PH_DROP,
      PH_BODY
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               command_seen_ff, command_seen_in;
   logic               origin_seen_ff, origin_seen_in;
   logic               body_seen_ff, body_seen_in;
   logic [PARAM_W-1:0] params_kept_ff, params_kept_in;
   logic [PARAM_W-1:0] max_params_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [PARAM_W-1:0] param_index_ff, param_index_in;
   logic               token_start_ff, token_start_in;
   logic               line_valid_ff, line_valid_in;
   logic [PARAM_W-1:0] param_count_ff, param_count_in;
   logic               has_origin_ff, has_origin_in;
   logic               has_body_ff, has_body_in;

   // Step when there is a request and the result stage is free or draining
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_if.ready);

   // Next line state and result
   always_comb begin
      phase_in        = phase_ff;
      command_seen_in = command_seen_ff;
      origin_seen_in  = origin_seen_ff;
      body_seen_in    = body_seen_ff;
      params_kept_in  = params_kept_ff;
      tag_in          = TAG_IGNORED;
      param_index_in  = '0;
      token_start_in  = 1'b0;
      line_valid_in   = 1'b0;
      param_count_in  = '0;
      has_origin_in   = 1'b0;
      has_body_in     = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (q_status.head == CLS_END) begin
            // Close an open line; otherwise the result is tagged ignored
            if (phase_ff != PH_IDLE) begin
               tag_in          = TAG_END;
               line_valid_in   = command_seen_ff;
               param_count_in  = params_kept_ff;
               has_origin_in   = origin_seen_ff;
               has_body_in     = body_seen_ff;
               phase_in        = PH_IDLE;
               command_seen_in = 1'b0;
               origin_seen_in  = 1'b0;
               body_seen_in    = 1'b0;
               params_kept_in  = '0;
            end
         end else if (phase_ff == PH_BODY) begin
            tag_in = TAG_BODY;
         end else if (q_status.head == CLS_COLON) begin
            // Colon at line start opens the origin, elsewhere the body
            if (phase_ff == PH_IDLE) begin
               tag_in   = TAG_PREFIX;
               phase_in = PH_ORIGIN;
            end else begin
               tag_in       = TAG_BCOLON;
               body_seen_in = 1'b1;
               phase_in     = PH_BODY;
            end
         end else if (q_status.head == CLS_SPACE) begin
            phase_in = PH_GAP;
         end else begin
            unique case (phase_ff)
               PH_ORIGIN: begin
                  tag_in         = TAG_ORIGIN;
                  token_start_in = !origin_seen_ff;
                  origin_seen_in = 1'b1;
               end
               PH_CMD: begin
                  tag_in = TAG_CMD;
               end
               PH_PARAM: begin
                  tag_in         = TAG_PARAM;
                  param_index_in = params_kept_ff - 1'b1;
               end
               PH_DROP: begin
                  tag_in = TAG_IGNORED;
               end
               default: begin
                  // New token after line start or a gap
                  if (!command_seen_ff) begin
                     command_seen_in = 1'b1;
                     phase_in        = PH_CMD;
                     tag_in          = TAG_CMD;
                     token_start_in  = 1'b1;
                  end else if (params_kept_ff < max_params_ff) begin
                     phase_in       = PH_PARAM;
                     tag_in         = TAG_PARAM;
                     param_index_in = params_kept_ff;
                     params_kept_in = params_kept_ff + 1'b1;
                     token_start_in = 1'b1;
                  end else begin
                     phase_in = PH_DROP;
                  end
               end
            endcase
         end
      end
   end

   // State and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         command_seen_ff <= 1'b0;
         origin_seen_ff  <= 1'b0;
         body_seen_ff    <= 1'b0;
         params_kept_ff  <= '0;
         max_params_ff   <= PARAM_LIMIT;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         command_seen_ff <= command_seen_in;
         origin_seen_ff  <= origin_seen_in;
         body_seen_ff    <= body_seen_in;
         params_kept_ff  <= params_kept_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) begin
            max_params_ff <= csr_wr_data;
         end
      end
      if (pop) begin
         tag_ff         <= tag_in;
         param_index_ff <= param_index_in;
         token_start_ff <= token_start_in;
         line_valid_ff  <= line_valid_in;
         param_count_ff <= param_count_in;
         has_origin_ff  <= has_origin_in;
         has_body_ff    <= has_body_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.tag         = tag_ff;
   assign rsp_if.param_index = param_index_ff;
   assign rsp_if.token_start = token_start_ff;
   assign rsp_if.line_valid  = line_valid_ff;
   assign rsp_if.param_count = param_count_ff;
   assign rsp_if.has_origin  = has_origin_ff;
   assign rsp_if.has_body    = has_body_ff;

endmodule

`default_nettype wire

// File: hdl/irc_line_field_tagger_core.sv
// ---------------------------------------------------------------------------
// irc_line_field_tagger_core
// Byte-stream line tagger: classifies each byte of a text line and reports
// a summary at the end of every non-empty line.
// ---------------------------------------------------------------------------
// One request (a byte or a flush) goes in per clock and exactly one result
// comes out for it, in order. A request is taken in every cycle while the
// queue between the classifier and the line state machine has room; the
// state machine steps once per cycle while the result stage is free or
// draining, so the sustained rate is one request per clock. Each result
// passes through the queue and then the registered result stage.
// The queue (QUEUE_DEPTH entries) absorbs result-side stalls. csr_wr_data
// sets the most parameters kept per line (reset 15); write it only while
// no requests are in flight.
`default_nettype none

module irc_line_field_tagger_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                          clock,
   input  wire                          reset,
   lftag_req_if.sink                    req_if,
   lftag_rsp_if.source                  rsp_if,
   input  wire                          csr_wr_en,
   input  wire [lftag_pkg::PARAM_W-1:0] csr_wr_data
);
   import lftag_pkg::*;

   q_push_type   q_push;
   q_status_type q_status;
   logic         pop;

   // Classifier
   lftag_front u_front (
      .req_if   (req_if),
      .q_status (q_status),
      .q_push   (q_push)
   );

   // Decoupling queue
   lftag_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (pop),
      .q_status (q_status)
   );

   // Line state machine and result stage
   lftag_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

`default_nettype wire

// File: hdl/lftag_checker.sv
// ---------------------------------------------------------------------------
// lftag_checker
// Port-level checks of the tagger's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lftag_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [lftag_pkg::TAG_W-1:0]   rsp_tag,
   input wire [lftag_pkg::PARAM_W-1:0] rsp_param_index,
   input wire                          rsp_token_start,
   input wire                          rsp_line_valid,
   input wire [lftag_pkg::PARAM_W-1:0] rsp_param_count,
   input wire                          rsp_has_origin,
   input wire                          rsp_has_body
);
   import lftag_pkg::*;

   localparam int unsigned PAYLOAD_W = TAG_W + 2 * PARAM_W + 4;

   logic [PAYLOAD_W-1:0] rsp_payload;
   logic                 tstart_tag;
   logic                 pidx_zero;

   // Whole result word, for the stability check
   assign rsp_payload = {rsp_tag, rsp_param_index, rsp_token_start, rsp_line_valid,
                         rsp_param_count, rsp_has_origin, rsp_has_body};

   // Tags that may open a token
   assign tstart_tag = (rsp_tag == TAG_ORIGIN) || (rsp_tag == TAG_CMD) ||
                       (rsp_tag == TAG_PARAM);

   assign pidx_zero = (rsp_param_index == '0);

   // No result straight after reset
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

   // A stalled result stays offered and unchanged
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))

   // Parameter index only on parameter characters
   `ASSERT_IMPLIES(a_pidx_param, clock, reset, rsp_valid && rsp_tag != TAG_PARAM, pidx_zero)

   // Token starts only on origin, command or parameter characters
   `ASSERT_IMPLIES(a_tstart_tag, clock, reset, rsp_valid && rsp_token_start, tstart_tag)

endmodule

bind irc_line_field_tagger_core lftag_checker u_lftag_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_tag         (rsp_if.tag),
   .rsp_param_index (rsp_if.param_index),
   .rsp_token_start (rsp_if.token_start),
   .rsp_line_valid  (rsp_if.line_valid),
   .rsp_param_count (rsp_if.param_count),
   .rsp_has_origin  (rsp_if.has_origin),
   .rsp_has_body    (rsp_if.has_body)
);

`default_nettype wire
